>>> hw/rtl/gbe_pkg.sv
// shared types, constants and register codes for the gamepad button edge block
package gbe_pkg;

	// field widths
	localparam int DATA_W      = 16;
	localparam int TRIG_W      = 8;
	localparam int DZ_W        = 15;
	localparam int PAD_IDX_W   = 2;
	localparam int BTN_IDX_W   = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 144;

	// module parameter defaults
	localparam int PAD_COUNT_DEF          = 4;
	localparam int BUTTON_COUNT_DEF       = 16;
	localparam int LEFT_TRIGGER_SLOT_DEF  = 10;
	localparam int RIGHT_TRIGGER_SLOT_DEF = 11;

	// remainder unit: digits retired per cycle and steps per operand
	localparam int REM_DIGITS = 4;
	localparam int REM_STEPS  = DATA_W / REM_DIGITS;
	localparam int REM_STEP_W = $clog2(REM_STEPS);

	// counter word limits
	localparam logic [DATA_W-1:0] WORD_MAX = 16'hFFFF;
	localparam logic [DATA_W-1:0] WORD_ONE = 16'h0001;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_DEADZONE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DEADZONE    = 2'd3;

	// configuration reset values
	localparam logic [DATA_W-1:0] RST_REPEAT_INTERVAL   = 16'd30;
	localparam logic [TRIG_W-1:0] RST_TRIGGER_THRESHOLD = 8'd30;
	localparam logic [DZ_W-1:0]   RST_LEFT_DEADZONE     = 15'd7849;
	localparam logic [DZ_W-1:0]   RST_RIGHT_DEADZONE    = 15'd8689;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIM_GO,
		ST_LIM_WAIT,
		ST_RD,
		ST_GO,
		ST_WAIT,
		ST_UPD,
		ST_DONE
	} state_t;

	// request into the remainder unit
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} rem_req_t;

	// status and result from the remainder unit
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] rem;
	} rem_rsp_t;

endpackage

>>> hw/rtl/gamepad_button_edge_repeat_core.sv
// top level: pad poll sequencer with edge, autorepeat, trigger and deadzone logic
//
// Each s_axis transaction polls one pad; each m_axis transaction carries the
// masks, trigger levels and stick axes. The user writes configuration via
// cfg_we / cfg_index / cfg_data only while idle; the block does not check.
//
// A connected poll steps through ST_LIM_GO and ST_LIM_WAIT, then ST_RD,
// ST_GO, ST_WAIT and ST_UPD for each button, then ST_DONE, and the next
// poll is taken in ST_IDLE after that. Each button reads its hold counter
// from the counter memory, runs the shared remainder unit (4 bits a cycle)
// for the interval test, and writes the counter back; one more remainder
// pass per poll gives the counter wrap limit. A disconnected poll or a pad
// index outside the pad count returns zeros through ST_DONE and the output
// register. s_axis_tready is high only while the sequencer is idle.
//
// The result sits in an output register, so a new poll is accepted while it
// waits; if m_axis_tready stays low the sequencer holds the next result
// until the register is free. Reset clears the previous button words, all
// hold counters (valid bits) and sets the registers to their defaults.
module gamepad_button_edge_repeat_core #(
	parameter int PAD_COUNT          = gbe_pkg::PAD_COUNT_DEF,
	parameter int BUTTON_COUNT       = gbe_pkg::BUTTON_COUNT_DEF,
	parameter int LEFT_TRIGGER_SLOT  = gbe_pkg::LEFT_TRIGGER_SLOT_DEF,
	parameter int RIGHT_TRIGGER_SLOT = gbe_pkg::RIGHT_TRIGGER_SLOT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// pad_index, pad_connected, button_bits, left_trigger_raw, right_trigger_raw,
	// left_stick_x, left_stick_y, right_stick_x, right_stick_y, zero fill
	input  logic [gbe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// pressed_mask, rise_mask, fall_mask, repeat_mask, left_trigger_level,
	// right_trigger_level, left_x_out, left_y_out, right_x_out, right_y_out
	output logic [gbe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            cfg_we,
	input  logic [gbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbe_pkg::DATA_W-1:0]      cfg_data
);

	localparam int PIDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
	localparam int DEPTH  = PAD_COUNT * BUTTON_COUNT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [gbe_pkg::BTN_IDX_W-1:0] LAST_BTN =
		gbe_pkg::BTN_IDX_W'(BUTTON_COUNT - 1);

	// input fields
	logic [gbe_pkg::PAD_IDX_W-1:0] in_pad;
	logic                          in_conn;
	logic [gbe_pkg::DATA_W-1:0]    in_buttons;
	logic [gbe_pkg::TRIG_W-1:0]    in_lt;
	logic [gbe_pkg::TRIG_W-1:0]    in_rt;
	logic [gbe_pkg::DATA_W-1:0]    in_lx;
	logic [gbe_pkg::DATA_W-1:0]    in_ly;
	logic [gbe_pkg::DATA_W-1:0]    in_rx;
	logic [gbe_pkg::DATA_W-1:0]    in_ry;

	assign in_pad     = s_axis_tdata[1:0];
	assign in_conn    = s_axis_tdata[2];
	assign in_buttons = s_axis_tdata[18:3];
	assign in_lt      = s_axis_tdata[26:19];
	assign in_rt      = s_axis_tdata[34:27];
	assign in_lx      = s_axis_tdata[50:35];
	assign in_ly      = s_axis_tdata[66:51];
	assign in_rx      = s_axis_tdata[82:67];
	assign in_ry      = s_axis_tdata[98:83];

	// configuration registers
	logic [gbe_pkg::DATA_W-1:0] interval_q;
	logic [gbe_pkg::TRIG_W-1:0] thresh_q;
	logic [gbe_pkg::DZ_W-1:0]   ldz_q;
	logic [gbe_pkg::DZ_W-1:0]   rdz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= gbe_pkg::RST_REPEAT_INTERVAL;
			thresh_q   <= gbe_pkg::RST_TRIGGER_THRESHOLD;
			ldz_q      <= gbe_pkg::RST_LEFT_DEADZONE;
			rdz_q      <= gbe_pkg::RST_RIGHT_DEADZONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbe_pkg::REG_REPEAT_INTERVAL:   interval_q <= cfg_data;
				gbe_pkg::REG_TRIGGER_THRESHOLD: thresh_q   <= cfg_data[gbe_pkg::TRIG_W-1:0];
				gbe_pkg::REG_LEFT_DEADZONE:     ldz_q      <= cfg_data[gbe_pkg::DZ_W-1:0];
				gbe_pkg::REG_RIGHT_DEADZONE:    rdz_q      <= cfg_data[gbe_pkg::DZ_W-1:0];
				default: ;
			endcase
		end
	end

	// zero interval behaves as one
	logic [gbe_pkg::DATA_W-1:0] ivl_eff;
	assign ivl_eff = (interval_q == '0) ? gbe_pkg::WORD_ONE : interval_q;

	// rebuilt button word with trigger flags in their slots
	logic [gbe_pkg::DATA_W-1:0] in_pressed;
	always_comb begin
		for (int b = 0; b < gbe_pkg::DATA_W; b++) begin
			if (b >= BUTTON_COUNT) begin
				in_pressed[b] = 1'b0;
			end else if (b == LEFT_TRIGGER_SLOT) begin
				in_pressed[b] = in_lt > thresh_q;
			end else if (b == RIGHT_TRIGGER_SLOT) begin
				in_pressed[b] = in_rt > thresh_q;
			end else begin
				in_pressed[b] = in_buttons[b];
			end
		end
	end

	// pad range check
	logic              in_ok;
	logic [PIDX_W-1:0] in_pidx;
	assign in_ok   = in_conn && ({3'b000, in_pad} < 5'(PAD_COUNT));
	assign in_pidx = PIDX_W'(in_pad);

	// sequencer state and per-poll registers
	gbe_pkg::state_t              state_q, state_d;
	logic [PIDX_W-1:0]            pad_q;
	logic                         pad_ok_q;
	logic [gbe_pkg::DATA_W-1:0]   pressed_q;
	logic [gbe_pkg::DATA_W-1:0]   prev_sel_q;
	logic [gbe_pkg::DATA_W-1:0]   rep_q;
	logic [gbe_pkg::DATA_W-1:0]   limit_q;
	logic [gbe_pkg::DATA_W-1:0]   cnt_inc_q;
	logic [gbe_pkg::BTN_IDX_W-1:0] btn_q;
	logic [gbe_pkg::TRIG_W-1:0]   lt_q, rt_q;
	logic [gbe_pkg::DATA_W-1:0]   lx_q, ly_q, rx_q, ry_q;
	logic [gbe_pkg::DATA_W-1:0]   prev_q [PAD_COUNT];

	gbe_pkg::rem_req_t          rem_req;
	gbe_pkg::rem_rsp_t          rem_rsp;
	logic [ADDR_W-1:0]          cnt_addr;
	logic [gbe_pkg::DATA_W-1:0] cnt_rdata;
	logic                       cnt_we;
	logic [gbe_pkg::DATA_W-1:0] cnt_wdata;
	logic                       accept;
	logic                       load_out;
	logic                       m_valid_q;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign cnt_addr = ADDR_W'(pad_q * BUTTON_COUNT) + ADDR_W'(btn_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbe_pkg::ST_IDLE:     if (s_axis_tvalid) state_d = in_ok ? gbe_pkg::ST_LIM_GO
				: gbe_pkg::ST_DONE;
			gbe_pkg::ST_LIM_GO:   state_d = gbe_pkg::ST_LIM_WAIT;
			gbe_pkg::ST_LIM_WAIT: if (rem_rsp.done) state_d = gbe_pkg::ST_RD;
			gbe_pkg::ST_RD:       state_d = gbe_pkg::ST_GO;
			gbe_pkg::ST_GO:       state_d = gbe_pkg::ST_WAIT;
			gbe_pkg::ST_WAIT:     if (rem_rsp.done) state_d = gbe_pkg::ST_UPD;
			gbe_pkg::ST_UPD:      state_d = (btn_q == LAST_BTN) ? gbe_pkg::ST_DONE
				: gbe_pkg::ST_RD;
			gbe_pkg::ST_DONE:     if (!m_valid_q || m_axis_tready) state_d = gbe_pkg::ST_IDLE;
			default:              state_d = gbe_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready    = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = gbe_pkg::WORD_MAX;
		rem_req.divisor  = ivl_eff;
		cnt_we           = 1'b0;
		cnt_wdata        = '0;
		load_out         = 1'b0;
		unique case (state_q)
			gbe_pkg::ST_IDLE:   s_axis_tready = 1'b1;
			gbe_pkg::ST_LIM_GO: rem_req.start = 1'b1;
			gbe_pkg::ST_GO: begin
				rem_req.start    = 1'b1;
				rem_req.dividend = cnt_rdata + gbe_pkg::WORD_ONE;
			end
			gbe_pkg::ST_UPD: begin
				cnt_we = 1'b1;
				if (pressed_q[btn_q] && (cnt_inc_q < limit_q)) begin
					cnt_wdata = cnt_inc_q;
				end
			end
			gbe_pkg::ST_DONE: load_out = !m_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-poll working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pad_q      <= in_pidx;
			pad_ok_q   <= in_ok;
			pressed_q  <= in_pressed;
			prev_sel_q <= in_ok ? prev_q[in_pidx] : '0;
			rep_q      <= '0;
			btn_q      <= '0;
			lt_q       <= in_lt;
			rt_q       <= in_rt;
			lx_q       <= in_lx;
			ly_q       <= in_ly;
			rx_q       <= in_rx;
			ry_q       <= in_ry;
		end
		if (state_q == gbe_pkg::ST_LIM_WAIT && rem_rsp.done) begin
			limit_q <= gbe_pkg::WORD_MAX - rem_rsp.rem;
		end
		if (state_q == gbe_pkg::ST_GO) begin
			cnt_inc_q <= cnt_rdata + gbe_pkg::WORD_ONE;
		end
		if (state_q == gbe_pkg::ST_UPD) begin
			btn_q <= btn_q + 1'b1;
			if (pressed_q[btn_q] && (!prev_sel_q[btn_q] || rem_rsp.rem == '0)) begin
				rep_q[btn_q] <= 1'b1;
			end
		end
	end

	// previous button word per pad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PAD_COUNT; p++) begin
				prev_q[p] <= '0;
			end
		end else if (load_out && pad_ok_q) begin
			prev_q[pad_q] <= pressed_q;
		end
	end

	// strict deadzone on one axis
	function automatic logic [gbe_pkg::DATA_W-1:0] dz_apply(
		input logic [gbe_pkg::DATA_W-1:0] v,
		input logic [gbe_pkg::DZ_W-1:0]   dz
	);
		logic signed [gbe_pkg::DATA_W:0] vs;
		logic signed [gbe_pkg::DATA_W:0] ds;
		vs = $signed({v[gbe_pkg::DATA_W-1], v});
		ds = $signed({2'b00, dz});
		return ((vs < ds) && (vs > -ds)) ? '0 : v;
	endfunction

	// output register
	logic [gbe_pkg::OUT_TDATA_W-1:0] out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (pad_ok_q) begin
				out_q <= {dz_apply(ry_q, rdz_q), dz_apply(rx_q, rdz_q),
					dz_apply(ly_q, ldz_q), dz_apply(lx_q, ldz_q), rt_q, lt_q,
					rep_q, prev_sel_q & ~pressed_q, pressed_q & ~prev_sel_q, pressed_q};
			end else begin
				out_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

	// shared remainder unit
	gbe_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// hold counters
	gbe_hold_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_hold_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (cnt_addr),
		.rd_data (cnt_rdata),
		.wr_en   (cnt_we),
		.wr_addr (cnt_addr),
		.wr_data (cnt_wdata)
	);

`ifndef SYNTHESIS
	a_edges_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[31:16] & m_axis_tdata[47:32]) == '0))
		else $error("rise and fall overlap");
	a_repeat_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[63:48] & ~m_axis_tdata[15:0]) == '0))
		else $error("repeat on released button");
	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !rem_rsp.busy)
		else $error("remainder unit busy while idle");
`endif

endmodule

>>> hw/rtl/gbe_rem.sv
// iterative remainder unit, several dividend bits retired per cycle
module gbe_rem (
	input  logic             clk,
	input  logic             arst_n,
	input  gbe_pkg::rem_req_t req,
	output gbe_pkg::rem_rsp_t rsp
);

	logic [gbe_pkg::DATA_W-1:0]     dvd_q;
	logic [gbe_pkg::DATA_W-1:0]     div_q;
	logic [gbe_pkg::DATA_W-1:0]     r_q;
	logic [gbe_pkg::REM_STEP_W-1:0] step_q;
	logic                           busy_q;
	logic                           done_q;
	logic [gbe_pkg::DATA_W-1:0]     r_next;

	// restoring steps for one cycle
	always_comb begin
		logic [gbe_pkg::DATA_W:0] r;
		r = {1'b0, r_q};
		for (int i = 0; i < gbe_pkg::REM_DIGITS; i++) begin
			r = {r[gbe_pkg::DATA_W-1:0], dvd_q[gbe_pkg::DATA_W-1-i]};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
			end
		end
		r_next = r[gbe_pkg::DATA_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == gbe_pkg::REM_STEP_W'(gbe_pkg::REM_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << gbe_pkg::REM_DIGITS;
			r_q   <= r_next;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = r_q;

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (r_q < div_q))
		else $error("remainder not below divisor");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("unit not busy after start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("done while still busy");
`endif

endmodule

>>> hw/rtl/gbe_hold_mem.sv
// hold counter memory with per-entry valid bits, registered read
module gbe_hold_mem #(
	parameter int DEPTH  = gbe_pkg::PAD_COUNT_DEF * gbe_pkg::BUTTON_COUNT_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [gbe_pkg::DATA_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [gbe_pkg::DATA_W-1:0] wr_data
);

	logic [gbe_pkg::DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]           valid_q;
	logic                       rvalid_q;
	logic [gbe_pkg::DATA_W-1:0] rdata_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// valid bits, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rvalid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule
